[sv/ncl_pkg.sv]
`timescale 1ns / 1ps
// constants, types and command codes for the nearest-centroid l1 search
// no dependencies; used by nearest_centroid_l1_search

package ncl_pkg;

  localparam int VECTOR_LEN    = 64;
  localparam int MAX_CENTROIDS = 16;

  localparam int CMD_W  = 1;
  localparam int CID_W  = 4;   // centroid index field width
  localparam int CNT_W  = 5;   // centroid count, holds MAX_CENTROIDS itself
  localparam int ELEM_W = 6;   // element index field width
  localparam int RANK_W = 6;
  localparam int DIST_W = 12;

  localparam int TABLE_DEPTH = MAX_CENTROIDS * VECTOR_LEN;
  localparam int TABLE_AW    = CID_W + ELEM_W;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [DIST_W-1:0] dist_t;

endpackage

[sv/ncl_ram.sv]
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies

module ncl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/nearest_centroid_l1_search.sv]
`timescale 1ns / 1ps
// nearest-centroid search by manhattan distance over rank vectors
// depends on ncl_pkg and ncl_ram
//
// channel   direction  handshake                 payload
// cfg       in         cfg_valid / cfg_ready     centroid_count
// in        in         in_valid / in_stall       command, centroid_index, element_index,
//                                                rank_value, last_element
// out       out        out_valid / out_stall     best_centroid, best_distance, none_found
//
// a centroid write is taken while idle and does not stall the input; a query element
// sweeps the n centroids in use, one centroid per cycle through the single read port
// of the distance ram, then drains; a query element with no centroid in use does not sweep
// after the last element of a query, the result waits in the done state for the result register
// reset (rst, synchronous) clears control, count and the distance valid bits;
// the centroid table is undefined until written
// in_stall is high while a query element sweeps and drains, and while a finished
// result waits for the output register; a result waiting in the output register
// under out_stall does not hold back new items

module nearest_centroid_l1_search (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ncl_pkg::CNT_W-1:0]         centroid_count,
  // item input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ncl_pkg::CMD_W-1:0]         command,
  input  logic [ncl_pkg::CID_W-1:0]         centroid_index,
  input  logic [ncl_pkg::ELEM_W-1:0]        element_index,
  input  logic [ncl_pkg::RANK_W-1:0]        rank_value,
  input  logic                              last_element,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ncl_pkg::CID_W-1:0]         best_centroid,
  output logic [ncl_pkg::DIST_W-1:0]        best_distance,
  output logic                              none_found
);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;  // issue reads, one centroid per cycle
  localparam logic [1:0] ST_DRAIN = 2'd2;  // last write-back in flight
  localparam logic [1:0] ST_DONE  = 2'd3;  // result waits for the output register

  localparam int CID_W  = ncl_pkg::CID_W;
  localparam int CNT_W  = ncl_pkg::CNT_W;
  localparam int ELEM_W = ncl_pkg::ELEM_W;
  localparam int DIST_W = ncl_pkg::DIST_W;

  logic [1:0] state, state_next;

  // configuration register
  logic [CNT_W-1:0] count_reg;
  logic [CNT_W-1:0] count_sat;

  // latched query element
  logic [CNT_W-1:0]           q_n;
  logic [ELEM_W-1:0]          q_eidx;
  ncl_pkg::rank_t             q_rank;
  logic                       q_add;
  logic                       q_last;

  // read stage
  logic [CID_W-1:0]           rd_idx;
  logic                       rd_final;

  // write-back stage
  logic                       wb_valid;
  logic [CID_W-1:0]           wb_idx;
  logic                       wb_old_valid;
  ncl_pkg::rank_t             rank_rd;
  ncl_pkg::dist_t             dist_rd;
  ncl_pkg::dist_t             dist_old;
  ncl_pkg::rank_t             diff;
  logic [DIST_W:0]            sum;
  ncl_pkg::dist_t             dist_new;

  // per-centroid valid bits: an entry not valid reads as zero
  logic [ncl_pkg::MAX_CENTROIDS-1:0] dist_valid;

  // running minimum
  ncl_pkg::dist_t             best_dist;
  logic [CID_W-1:0]           best_idx;

  logic in_accept;
  logic wr_ok;
  logic elem_ok;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // count above the table size saturates
  assign count_sat = (count_reg > CNT_W'(ncl_pkg::MAX_CENTROIDS))
                   ? CNT_W'(ncl_pkg::MAX_CENTROIDS) : count_reg;

  assign elem_ok = ({1'b0, element_index} < (ELEM_W + 1)'(ncl_pkg::VECTOR_LEN));
  assign wr_ok   = elem_ok
                && ({1'b0, centroid_index} < (CID_W + 1)'(ncl_pkg::MAX_CENTROIDS));

  assign rd_final = ({1'b0, rd_idx} == (q_n - CNT_W'(1)));

  // centroid table, addressed {centroid, element}
  ncl_ram #(
    .WIDTH (ncl_pkg::RANK_W),
    .DEPTH (ncl_pkg::TABLE_DEPTH)
  ) u_rank_ram (
    .clk   (clk),
    .we    (in_accept && (command == ncl_pkg::CMD_WRITE) && wr_ok),
    .waddr ({centroid_index, element_index}),
    .wdata (rank_value),
    .raddr ({rd_idx, q_eidx}),
    .rdata (rank_rd)
  );

  // running distances, read in the cycle before the write-back
  ncl_ram #(
    .WIDTH (DIST_W),
    .DEPTH (ncl_pkg::MAX_CENTROIDS)
  ) u_dist_ram (
    .clk   (clk),
    .we    (wb_valid),
    .waddr (wb_idx),
    .wdata (dist_new),
    .raddr (rd_idx),
    .rdata (dist_rd)
  );

  // absolute difference and saturating add
  always_comb begin
    dist_old = wb_old_valid ? dist_rd : '0;
    if (!q_add) begin
      diff = '0;
    end else if (q_rank > rank_rd) begin
      diff = q_rank - rank_rd;
    end else begin
      diff = rank_rd - q_rank;
    end
    sum      = {1'b0, dist_old} + (DIST_W + 1)'(diff);
    dist_new = sum[DIST_W] ? ncl_pkg::DIST_MAX : sum[DIST_W-1:0];
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && (command == ncl_pkg::CMD_QUERY)) begin
          if (count_sat != '0) begin
            state_next = ST_SWEEP;
          end else if (last_element) begin
            state_next = ST_DONE;  // nothing in use, report none found
          end
        end
      end
      ST_SWEEP: begin
        if (rd_final) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = q_last ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count_reg  <= '0;
      rd_idx     <= '0;
      wb_valid   <= 1'b0;
      dist_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        count_reg <= centroid_count;
      end

      // read pointer walks the centroids in use
      if (state == ST_SWEEP) begin
        rd_idx <= rd_final ? '0 : rd_idx + CID_W'(1);
      end else begin
        rd_idx <= '0;
      end
      wb_valid <= (state == ST_SWEEP);

      if (wb_valid) begin
        dist_valid[wb_idx] <= 1'b1;
      end

      // result goes out, all running distances restart at zero
      if ((state == ST_DONE) && out_free) begin
        out_valid  <= 1'b1;
        dist_valid <= '0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_n    <= count_sat;
      q_eidx <= element_index;
      q_rank <= rank_value;
      q_add  <= elem_ok;
      q_last <= last_element;
    end

    wb_idx       <= rd_idx;
    wb_old_valid <= dist_valid[rd_idx];

    // strict compare keeps the lowest index on ties
    if (wb_valid && ((wb_idx == '0) || (dist_new < best_dist))) begin
      best_dist <= dist_new;
      best_idx  <= wb_idx;
    end

    if ((state == ST_DONE) && out_free) begin
      if (q_n == '0) begin
        best_centroid <= '0;
        best_distance <= '0;
        none_found    <= 1'b1;
      end else begin
        best_centroid <= best_idx;
        best_distance <= best_dist;
        none_found    <= 1'b0;
      end
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for nearest_centroid_l1_search: table writes, l1 queries, results
// depends on ncl_pkg and the nearest_centroid_l1_search rtl

module tb;

  localparam int SETTLE_CYCLES = 24;      // worst item sweep plus result load, with margin
  localparam int CYCLE_LIMIT   = 600000;  // several times the slowest legal run
  localparam int IDLE_PERCENT  = 37;

  // one search result as seen on the output port
  typedef struct packed {
    logic [ncl_pkg::CID_W-1:0] best_centroid;
    ncl_pkg::dist_t            best_distance;
    logic                      none_found;
  } nearest_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [ncl_pkg::CNT_W-1:0]   centroid_count = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [ncl_pkg::CMD_W-1:0]   command = ncl_pkg::CMD_WRITE;
  logic [ncl_pkg::CID_W-1:0]   centroid_index = '0;
  logic [ncl_pkg::ELEM_W-1:0]  element_index = '0;
  ncl_pkg::rank_t              rank_value = '0;
  logic                        last_element = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [ncl_pkg::CID_W-1:0]   best_centroid;
  ncl_pkg::dist_t              best_distance;
  logic                        none_found;

  // shadow copy of the block state
  ncl_pkg::rank_t              table_rank    [ncl_pkg::TABLE_DEPTH];
  bit                          table_written [ncl_pkg::TABLE_DEPTH];
  ncl_pkg::dist_t              sum_dist      [ncl_pkg::MAX_CENTROIDS];
  logic [ncl_pkg::CNT_W-1:0]   count_reg;

  nearest_t           pending_nearest [$];
  int                 error_count = 0;
  int                 cycle_count = 0;
  int                 items_sent = 0;   // every accepted input item, table fills included
  bit                 no_idle = 1'b0;   // set for a long stretch with both sides always ready

  nearest_centroid_l1_search dut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .centroid_count,
    .in_valid, .in_stall, .command, .centroid_index, .element_index, .rank_value,
    .last_element,
    .out_valid, .out_stall, .best_centroid, .best_distance, .none_found
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stalls at random, except in the quiet stretch
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  task automatic report(input string what, input int want_v, input int got_v);
    error_count++;
    if (error_count <= 10)
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want_v, got_v);
  endtask

  // centroid count above the table size is clamped when used
  function automatic int centroids_in_use();
    return (count_reg > ncl_pkg::MAX_CENTROIDS) ? ncl_pkg::MAX_CENTROIDS : int'(count_reg);
  endfunction

  // a query element may only touch table entries already written
  function automatic bit column_ready(input int eidx);
    int n;
    n = centroids_in_use();
    for (int row = 0; row < n; row++)
      if (!table_written[row * ncl_pkg::VECTOR_LEN + eidx]) return 1'b0;
    return 1'b1;
  endfunction

  // update the shadow state for one accepted item, queue the nearest centroid on a last element
  function automatic void score_item(input logic [ncl_pkg::CMD_W-1:0] cmd,
                                     input logic [ncl_pkg::CID_W-1:0] cid,
                                     input logic [ncl_pkg::ELEM_W-1:0] eidx,
                                     input ncl_pkg::rank_t rank,
                                     input logic last);
    int       n;
    int       stored;
    int       diff;
    int       total;
    int       best;
    nearest_t res;
    n = centroids_in_use();
    if (cmd == ncl_pkg::CMD_WRITE) begin
      // last flag on a write is ignored, no result
      table_rank[{cid, eidx}]    = rank;
      table_written[{cid, eidx}] = 1'b1;
      return;
    end
    for (int row = 0; row < n; row++) begin
      stored = table_rank[row * ncl_pkg::VECTOR_LEN + int'(eidx)];
      diff   = (rank > stored) ? int'(rank) - stored : stored - int'(rank);
      total  = int'(sum_dist[row]) + diff;
      // each running distance saturates
      sum_dist[row] = (total > int'(ncl_pkg::DIST_MAX)) ? ncl_pkg::DIST_MAX
                                                         : ncl_pkg::DIST_W'(total);
    end
    if (!last) return;
    if (n == 0) begin
      // nothing in use: flagged, zero index and distance
      res.best_centroid = '0;
      res.best_distance = '0;
      res.none_found    = 1'b1;
    end else begin
      best = 0;
      // strict compare keeps the lowest index on ties
      for (int row = 1; row < n; row++)
        if (sum_dist[row] < sum_dist[best]) best = row;
      res.best_centroid = best[ncl_pkg::CID_W-1:0];
      res.best_distance = sum_dist[best];
      res.none_found    = 1'b0;
    end
    pending_nearest = {pending_nearest, res};
    for (int row = 0; row < ncl_pkg::MAX_CENTROIDS; row++) sum_dist[row] = '0;
  endfunction

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    nearest_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_nearest.size() == 0) begin
        report("result with nothing pending, best_centroid", -1, best_centroid);
      end else begin
        want = pending_nearest.pop_front();
        if (best_centroid !== want.best_centroid)
          report("best_centroid", want.best_centroid, best_centroid);
        if (best_distance !== want.best_distance)
          report("best_distance", want.best_distance, best_distance);
        if (none_found !== want.none_found)
          report("none_found", want.none_found, none_found);
      end
    end
  end

  // one item on the input channel; valid stays high into the next item unless a gap is taken
  task automatic send_item(input logic [ncl_pkg::CMD_W-1:0] cmd,
                           input logic [ncl_pkg::CID_W-1:0] cid,
                           input logic [ncl_pkg::ELEM_W-1:0] eidx,
                           input ncl_pkg::rank_t rank, input logic last);
    int gap;
    gap = 0;
    if (!no_idle)
      while ($urandom_range(0, 99) < IDLE_PERCENT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    command        <= cmd;
    centroid_index <= cid;
    element_index  <= eidx;
    rank_value     <= rank;
    last_element   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    score_item(cmd, cid, eidx, rank, last);
  endtask

  // drop valid, then wait until all results are in and the last sweep has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_centroid_count(input logic [ncl_pkg::CNT_W-1:0] value);
    drain();
    cfg_valid      <= 1'b1;
    centroid_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    count_reg = value;
  endtask

  // write one element position for every centroid with random ranks
  task automatic fill_column(input int eidx);
    for (int row = 0; row < ncl_pkg::MAX_CENTROIDS; row++)
      send_item(ncl_pkg::CMD_WRITE, row[ncl_pkg::CID_W-1:0], eidx[ncl_pkg::ELEM_W-1:0],
                ncl_pkg::RANK_W'($urandom), 1'($urandom));
  endtask

  // query element at a mostly already-written position; a fresh one gets its column filled first
  task automatic send_query_element(input logic last);
    int eidx;
    int tries;
    eidx = $urandom_range(0, ncl_pkg::VECTOR_LEN - 1);
    if ($urandom_range(0, 99) < 75)
      for (tries = 0; tries < 8 && !column_ready(eidx); tries++)
        eidx = $urandom_range(0, ncl_pkg::VECTOR_LEN - 1);
    if (!column_ready(eidx)) fill_column(eidx);
    send_item(ncl_pkg::CMD_QUERY, ncl_pkg::CID_W'($urandom), eidx[ncl_pkg::ELEM_W-1:0],
              ncl_pkg::RANK_W'($urandom), last);
  endtask

  // count 0 after reset: a query ends with none_found; last flag on a write is ignored
  task automatic test_no_centroids();
    send_item(ncl_pkg::CMD_WRITE, 4'd15, 6'd63, 6'd63, 1'b1);
    send_item(ncl_pkg::CMD_QUERY, 4'd15, 6'd63, 6'd0, 1'b0);
    send_item(ncl_pkg::CMD_QUERY, 4'd0, 6'd0, 6'd63, 1'b1);
    set_centroid_count(5'd0);
    send_item(ncl_pkg::CMD_QUERY, 4'd9, 6'd32, 6'd31, 1'b1);
  endtask

  // extreme ranks at the first and last element, full table and a count above the table
  task automatic test_extremes();
    for (int row = 0; row < ncl_pkg::MAX_CENTROIDS; row++) begin
      send_item(ncl_pkg::CMD_WRITE, row[ncl_pkg::CID_W-1:0], 6'd0,
                row[0] ? 6'd63 : 6'd0, 1'b0);
      send_item(ncl_pkg::CMD_WRITE, row[ncl_pkg::CID_W-1:0], 6'd63,
                row[0] ? 6'd0 : 6'd63, 1'b0);
    end
    set_centroid_count(5'd31);
    send_item(ncl_pkg::CMD_QUERY, 4'd0, 6'd0, 6'd63, 1'b0);
    send_item(ncl_pkg::CMD_QUERY, 4'd15, 6'd63, 6'd0, 1'b1);
    set_centroid_count(5'd16);
    send_item(ncl_pkg::CMD_QUERY, 4'd0, 6'd0, 6'd0, 1'b0);
    send_item(ncl_pkg::CMD_QUERY, 4'd0, 6'd63, 6'd0, 1'b1);
    send_item(ncl_pkg::CMD_QUERY, 4'd0, 6'd63, 6'd31, 1'b1);
  endtask

  // equal distances resolve to the lowest index
  task automatic test_tie_break();
    send_item(ncl_pkg::CMD_WRITE, 4'd0, 6'd5, 6'd40, 1'b0);
    send_item(ncl_pkg::CMD_WRITE, 4'd1, 6'd5, 6'd40, 1'b0);
    send_item(ncl_pkg::CMD_WRITE, 4'd2, 6'd5, 6'd20, 1'b0);
    send_item(ncl_pkg::CMD_WRITE, 4'd3, 6'd5, 6'd20, 1'b0);
    set_centroid_count(5'd4);
    send_item(ncl_pkg::CMD_QUERY, 4'd0, 6'd5, 6'd30, 1'b1);
    send_item(ncl_pkg::CMD_QUERY, 4'd0, 6'd5, 6'd10, 1'b1);
  endtask

  // count changes between elements of one query, both down and up
  task automatic test_count_change();
    set_centroid_count(5'd3);
    send_item(ncl_pkg::CMD_QUERY, 4'd0, 6'd0, 6'd17, 1'b0);
    set_centroid_count(5'd2);
    send_item(ncl_pkg::CMD_QUERY, 4'd0, 6'd63, 6'd5, 1'b1);
    set_centroid_count(5'd1);
    send_item(ncl_pkg::CMD_QUERY, 4'd0, 6'd0, 6'd50, 1'b0);
    set_centroid_count(5'd3);
    send_item(ncl_pkg::CMD_QUERY, 4'd0, 6'd63, 6'd44, 1'b1);
  endtask

  // a long query with repeated elements drives the running distances to saturation
  task automatic test_saturation();
    send_item(ncl_pkg::CMD_WRITE, 4'd0, 6'd0, 6'd0, 1'b0);
    send_item(ncl_pkg::CMD_WRITE, 4'd1, 6'd0, 6'd0, 1'b0);
    set_centroid_count(5'd2);
    for (int k = 0; k < 66; k++)
      send_item(ncl_pkg::CMD_QUERY, 4'd0, 6'd0, 6'd63, k == 65);
  endtask

  // random query vectors of random content mixed with random table writes
  task automatic test_random_traffic();
    int unsigned fixed_counts [4] = '{16, 31, 0, 5};
    int          stop_at;
    int          len;
    for (int phase = 0; phase < 8; phase++) begin
      set_centroid_count(phase < 4 ? ncl_pkg::CNT_W'(fixed_counts[phase])
                                   : ncl_pkg::CNT_W'($urandom_range(0, 31)));
      no_idle = (phase == 1);
      stop_at = items_sent + 85;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 99) < 25) begin
          send_item(ncl_pkg::CMD_WRITE, ncl_pkg::CID_W'($urandom), ncl_pkg::ELEM_W'($urandom),
                    ncl_pkg::RANK_W'($urandom), 1'($urandom));
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          for (int k = 0; k < len; k++) send_query_element(k == len - 1);
        end
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    for (int k = 0; k < ncl_pkg::TABLE_DEPTH; k++) begin
      table_rank[k]    = '0;
      table_written[k] = 1'b0;
    end
    for (int k = 0; k < ncl_pkg::MAX_CENTROIDS; k++) sum_dist[k] = '0;
    count_reg = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_centroids();
    test_extremes();
    test_tie_break();
    test_count_change();
    test_saturation();
    test_random_traffic();

    drain();
    if (pending_nearest.size() != 0)
      report("results never delivered", 0, pending_nearest.size());
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
